// ===== sv/tah_pkg.sv =====
// Shared constants for the Heron triangle area pipeline.
package tah_pkg;

    localparam int FIELD_W         = 16;
    localparam int AREA_W          = 24;
    localparam int COORD_BITS_DEF  = 16;
    localparam int ROOT_SHIFT      = 10;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

endpackage

// ===== sv/triangle_area_heron.sv =====
// Heron triangle area: pipelined side roots, factor product and final root.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  s_      | in        | s_valid / s_ready  | s_ax s_bx s_cx s_ay s_by s_cy (16b)
//  m_      | out       | m_valid / m_ready  | m_area (24b, unsigned, area/256)
//
// One triangle per cycle unless a stall on m_ready holds it. Stages, in order: three
// difference/square stages, one stage per side root bit, four factor/product stages,
// one stage per area root bit and the output register.
// Reset clears the valid bits of every stage. A stall on m_ready holds the
// whole pipeline in place and drops s_ready in the same cycle.
module triangle_area_heron
    import tah_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FIELD_W-1:0]  s_ax,
    input  logic [FIELD_W-1:0]  s_bx,
    input  logic [FIELD_W-1:0]  s_cx,
    input  logic [FIELD_W-1:0]  s_ay,
    input  logic [FIELD_W-1:0]  s_by,
    input  logic [FIELD_W-1:0]  s_cy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [AREA_W-1:0]   m_area
);

    // coordinate bits in use, side root bits, product and root widths
    localparam int CW  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SB  = CW + 1;
    localparam int SRW = SB + 3;
    localparam int XW  = 2*SB + 3;
    localparam int YW  = 2*SB + 2;
    localparam int H   = SB + 1;
    localparam int PW  = XW + YW;
    localparam int RB  = (PW + 1) / 2;
    localparam int RRW = RB + 3;

    logic en;

    logic            v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v7_reg;
    logic            vs_reg [SB+1];
    logic            vr_reg [RB];

    logic [CW-1:0]   dx_reg [3];
    logic [CW-1:0]   dy_reg [3];
    logic [2*CW-1:0] sqx_reg [3];
    logic [2*CW-1:0] sqy_reg [3];

    logic [2*SB-1:0] srad_reg  [3][SB+1];
    logic [SRW-1:0]  srem_reg  [3][SB+1];
    logic [SB-1:0]   sroot_reg [3][SB+1];

    logic [SB+1:0]   sum_reg;
    logic [SB:0]     fa_reg, fb_reg, fc_reg;
    logic [XW-1:0]   mx_reg;
    logic [YW-1:0]   my_reg;
    logic [2*H:0]    pll_reg, plh_reg, phl_reg, phh_reg;

    logic [2*RB-1:0] rrad_reg  [RB+1];
    logic [RRW-1:0]  rrem_reg  [RB+1];
    logic [RB-1:0]   rroot_reg [RB+1];

    logic [AREA_W-1:0] area_reg;

    logic [CW-1:0]   px [3], py [3], qx [3], qy [3];

    // whole pipeline moves unless the output item is held
    assign en      = !v7_reg || m_ready;
    assign s_ready = en;
    assign m_valid = v7_reg;
    assign m_area  = area_reg;

    // side endpoints: a = A-B, b = A-C, c = B-C
    assign px[0] = s_ax[CW-1:0]; assign py[0] = s_ay[CW-1:0];
    assign qx[0] = s_bx[CW-1:0]; assign qy[0] = s_by[CW-1:0];
    assign px[1] = s_ax[CW-1:0]; assign py[1] = s_ay[CW-1:0];
    assign qx[1] = s_cx[CW-1:0]; assign qy[1] = s_cy[CW-1:0];
    assign px[2] = s_bx[CW-1:0]; assign py[2] = s_by[CW-1:0];
    assign qx[2] = s_cx[CW-1:0]; assign qy[2] = s_cy[CW-1:0];

    // valid bits; vr_reg[k] travels with root stage k+1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0; v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v7_reg <= 1'b0;
            for (int k = 0; k <= SB; k++) vs_reg[k] <= 1'b0;
            for (int k = 0; k < RB; k++) vr_reg[k] <= 1'b0;
        end else if (en) begin
            v0_reg    <= s_valid;
            v1_reg    <= v0_reg;
            vs_reg[0] <= v1_reg;
            for (int k = 0; k < SB; k++) vs_reg[k+1] <= vs_reg[k];
            v2_reg    <= vs_reg[SB];
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vr_reg[0] <= v5_reg;
            for (int k = 0; k < RB-1; k++) vr_reg[k+1] <= vr_reg[k];
            v7_reg    <= vr_reg[RB-1];
        end
    end

    // differences, squares, squared lengths
    generate
        for (genvar s = 0; s < 3; s++) begin : g_side
            always_ff @(posedge aclk) begin
                if (en) begin
                    dx_reg[s]  <= (px[s] > qx[s]) ? px[s] - qx[s] : qx[s] - px[s];
                    dy_reg[s]  <= (py[s] > qy[s]) ? py[s] - qy[s] : qy[s] - py[s];
                    sqx_reg[s] <= dx_reg[s] * dx_reg[s];
                    sqy_reg[s] <= dy_reg[s] * dy_reg[s];
                    srad_reg[s][0]  <= {1'b0, ({1'b0, sqx_reg[s]} + {1'b0, sqy_reg[s]})};
                    srem_reg[s][0]  <= '0;
                    sroot_reg[s][0] <= '0;
                end
            end

            // side root, one bit per stage
            for (genvar k = 0; k < SB; k++) begin : g_sstep
                logic [SRW-1:0] cur, trial;
                logic           ge;
                assign cur   = {srem_reg[s][k][SRW-3:0], srad_reg[s][k][2*SB-1 -: 2]};
                assign trial = {1'b0, sroot_reg[s][k], 2'b01};
                assign ge    = cur >= trial;
                always_ff @(posedge aclk) begin
                    if (en) begin
                        srad_reg[s][k+1]  <= srad_reg[s][k] << 2;
                        srem_reg[s][k+1]  <= ge ? cur - trial : cur;
                        sroot_reg[s][k+1] <= {sroot_reg[s][k][SB-2:0], ge};
                    end
                end
            end
        end
    endgenerate

    // Heron factors, clamped at zero
    logic [SB:0] sbc, sac, sab;
    logic [SB-1:0] la, lb, lc;
    assign la  = sroot_reg[0][SB];
    assign lb  = sroot_reg[1][SB];
    assign lc  = sroot_reg[2][SB];
    assign sbc = {1'b0, lb} + {1'b0, lc};
    assign sac = {1'b0, la} + {1'b0, lc};
    assign sab = {1'b0, la} + {1'b0, lb};

    // factor stage, two products, partial products, full product
    logic [H-1:0]    xl, yl;
    logic [XW-H-1:0] xh;
    logic [YW-H-1:0] yh;
    logic [PW:0]     pfull;
    assign xl = mx_reg[H-1:0];
    assign xh = mx_reg[XW-1:H];
    assign yl = my_reg[H-1:0];
    assign yh = my_reg[YW-1:H];
    assign pfull = (PW+1)'(pll_reg) + ((PW+1)'(plh_reg) << H)
                 + ((PW+1)'(phl_reg) << H) + ((PW+1)'(phh_reg) << (2*H));

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= {1'b0, sbc} + {2'b0, la};
            fa_reg  <= (sbc > {1'b0, la}) ? sbc - {1'b0, la} : '0;
            fb_reg  <= (sac > {1'b0, lb}) ? sac - {1'b0, lb} : '0;
            fc_reg  <= (sab > {1'b0, lc}) ? sab - {1'b0, lc} : '0;
            mx_reg  <= sum_reg * fa_reg;
            my_reg  <= fb_reg * fc_reg;
            pll_reg <= (2*H+1)'(xl * yl);
            plh_reg <= (2*H+1)'(xl * yh);
            phl_reg <= (2*H+1)'(xh * yl);
            phh_reg <= (2*H+1)'(xh * yh);
            rrad_reg[0]  <= (2*RB)'(pfull);
            rrem_reg[0]  <= '0;
            rroot_reg[0] <= '0;
        end
    end

    // area root, one bit per stage
    generate
        for (genvar k = 0; k < RB; k++) begin : g_rstep
            logic [RRW-1:0] cur, trial;
            logic           ge;
            assign cur   = {rrem_reg[k][RRW-3:0], rrad_reg[k][2*RB-1 -: 2]};
            assign trial = {1'b0, rroot_reg[k], 2'b01};
            assign ge    = cur >= trial;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rrad_reg[k+1]  <= rrad_reg[k] << 2;
                    rrem_reg[k+1]  <= ge ? cur - trial : cur;
                    rroot_reg[k+1] <= {rroot_reg[k][RB-2:0], ge};
                end
            end
        end
    endgenerate

    // scale and saturate into the output register
    logic [RB+AREA_W-1:0] scaled;
    assign scaled = {{AREA_W{1'b0}}, rroot_reg[RB]} >> ROOT_SHIFT;

    always_ff @(posedge aclk) begin
        if (en) begin
            area_reg <= (scaled > {{RB{1'b0}}, AREA_MAX}) ? AREA_MAX : scaled[AREA_W-1:0];
        end
    end

endmodule
